[design/ftpo_pkg.sv]
// Shared widths, codes and constants of the first-touch page owner tracker.
package ftpo_pkg;

   localparam int PAGE_W   = 52;
   localparam int ID_W     = 7;
   localparam int OWNER_W  = 8;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 2;

   // Owner code of a page that no node has touched yet
   localparam logic [OWNER_W-1:0] UNOWNED = 8'hFF;

   // Access status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_LOCAL     = 2'd0,
      STATUS_REMOTE    = 2'd1,
      STATUS_UNTRACKED = 2'd2
   } status_type;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MMAP_LOW  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MMAP_HIGH = 2'd3;

endpackage

[design/ftpo_if.sv]
// Valid/ready channel interfaces of the first-touch page owner tracker.
interface ftpo_req_if;
   logic                          valid;
   logic                          ready;
   logic [ftpo_pkg::PAGE_W-1:0]   page_number;
   logic [ftpo_pkg::ID_W-1:0]     requester_id;

   modport source (output valid, output page_number, output requester_id, input ready);
   modport sink   (input valid, input page_number, input requester_id, output ready);
endinterface

interface ftpo_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ftpo_pkg::STATUS_W-1:0] status;

   modport source (output valid, output status, input ready);
   modport sink   (input valid, input status, output ready);
endinterface

interface ftpo_csr_if;
   logic                           valid;
   logic                           ready;
   logic [ftpo_pkg::CSR_IDX_W-1:0] index;
   logic [ftpo_pkg::PAGE_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[design/ftpo_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ftpo_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output logic [WIDTH-1:0]      rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[design/first_touch_page_owner.sv]
// Top level of the first-touch page owner tracker.
// Usage:
//  - req_bus carries one access (page_number, requester_id) per transfer.
//  - rsp_bus returns one status per access, in order: local, remote or not
//    tracked. A page in a region with no owner yet is claimed by the requester.
//  - csr_bus writes the region bounds (heap low/high, mmap low/high); it is
//    always ready. Write it only while no access is in flight.
// Timing:
//  - An access passes through a register step, then the region check and the owner
//    RAM read, then a decide step that writes back a claim and loads the
//    response register. The next access is taken in the cycle after that, so
//    no new access is taken while one is in flight; this is set by the registered
//    read of the owner RAMs and the read-modify-write of one entry.
//  - The response sits in an output register; a new access may be taken while
//    it waits. If rsp_bus stalls, the next access holds in the decide step
//    until the response register is free.
// Reset:
//  - Bounds return to empty regions. Both owner RAMs are then swept to the
//    unowned code, one entry per cycle in parallel; req_bus is not ready
//    during the sweep.
module first_touch_page_owner #(
   parameter int PAGES = 4096
) (
   input  logic       clock,
   input  logic       reset,
   ftpo_req_if.sink   req_bus,
   ftpo_rsp_if.source rsp_bus,
   ftpo_csr_if.sink   csr_bus
);
   localparam int AW = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int PW = ftpo_pkg::PAGE_W;

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_LOOK   = 4'b0100,
      ST_DECIDE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [PW-1:0] heap_low_ff, heap_high_ff, mmap_low_ff, mmap_high_ff;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   logic [PW-1:0]                page_ff;
   logic [ftpo_pkg::ID_W-1:0]    who_ff;
   logic                         use_mmap_ff, use_mmap_in;
   logic                         use_heap_ff, use_heap_in;
   logic [AW-1:0]                mmap_addr_ff, heap_addr_ff;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [ftpo_pkg::STATUS_W-1:0]   status_ff, status_in;

   logic [PW-1:0] mmap_off, heap_off;
   logic          mmap_in_rgn, heap_in_rgn;
   logic          mmap_fit, heap_fit;

   logic [ftpo_pkg::OWNER_W-1:0] mmap_rd, heap_rd, owner;
   logic [ftpo_pkg::OWNER_W-1:0] wr_data;
   logic                         clearing, look, done, claim;
   logic                         mmap_we, heap_we;
   logic [AW-1:0]                mmap_wr_addr, heap_wr_addr;

   // Configuration writes
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_low_ff  <= '1;
         heap_high_ff <= '0;
         mmap_low_ff  <= '1;
         mmap_high_ff <= '0;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            ftpo_pkg::CSR_HEAP_LOW:  heap_low_ff  <= csr_bus.data;
            ftpo_pkg::CSR_HEAP_HIGH: heap_high_ff <= csr_bus.data;
            ftpo_pkg::CSR_MMAP_LOW:  mmap_low_ff  <= csr_bus.data;
            ftpo_pkg::CSR_MMAP_HIGH: mmap_high_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // Region check on the registered access; mmap wins over heap
   always_comb begin
      mmap_in_rgn = (mmap_low_ff <= mmap_high_ff) && (page_ff >= mmap_low_ff)
                    && (page_ff <= mmap_high_ff);
      heap_in_rgn = (heap_low_ff <= heap_high_ff) && (page_ff >= heap_low_ff)
                    && (page_ff <= heap_high_ff);
      mmap_off    = page_ff - mmap_low_ff;
      heap_off    = page_ff - heap_low_ff;
      mmap_fit    = mmap_off < PW'(PAGES);
      heap_fit    = heap_off < PW'(PAGES);
      use_mmap_in = mmap_in_rgn && mmap_fit;
      use_heap_in = !mmap_in_rgn && heap_in_rgn && heap_fit;
   end

   // Decide step: owner compare, claim and response
   assign clearing = (state_ff == ST_CLEAR);
   assign look     = (state_ff == ST_LOOK);
   assign done     = (state_ff == ST_DECIDE) && (!rsp_valid_ff || rsp_bus.ready);
   assign owner    = use_mmap_ff ? mmap_rd : heap_rd;
   assign claim    = done && (use_mmap_ff || use_heap_ff) && (owner == ftpo_pkg::UNOWNED);

   always_comb begin
      if (!use_mmap_ff && !use_heap_ff) begin
         status_in = ftpo_pkg::STATUS_UNTRACKED;
      end else if (owner == ftpo_pkg::UNOWNED || owner == {1'b0, who_ff}) begin
         status_in = ftpo_pkg::STATUS_LOCAL;
      end else begin
         status_in = ftpo_pkg::STATUS_REMOTE;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(PAGES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         page_ff <= req_bus.page_number;
         who_ff  <= req_bus.requester_id;
      end
      if (look) begin
         use_mmap_ff  <= use_mmap_in;
         use_heap_ff  <= use_heap_in;
         mmap_addr_ff <= mmap_off[AW-1:0];
         heap_addr_ff <= heap_off[AW-1:0];
      end
      if (done) begin
         status_ff <= status_in;
      end
   end

   assign req_bus.ready  = (state_ff == ST_IDLE);
   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.status = status_ff;

   // Owner RAM write ports: clearing sweep or claim write-back
   assign wr_data      = clearing ? ftpo_pkg::UNOWNED : {1'b0, who_ff};
   assign mmap_we      = clearing || (claim && use_mmap_ff);
   assign heap_we      = clearing || (claim && use_heap_ff);
   assign mmap_wr_addr = clearing ? clr_addr_ff : mmap_addr_ff;
   assign heap_wr_addr = clearing ? clr_addr_ff : heap_addr_ff;

   ftpo_ram #(
      .WIDTH (ftpo_pkg::OWNER_W),
      .DEPTH (PAGES)
   ) u_mmap_ram (
      .clock   (clock),
      .wr_en   (mmap_we),
      .wr_addr (mmap_wr_addr),
      .wr_data (wr_data),
      .rd_en   (look),
      .rd_addr (mmap_off[AW-1:0]),
      .rd_data (mmap_rd)
   );

   ftpo_ram #(
      .WIDTH (ftpo_pkg::OWNER_W),
      .DEPTH (PAGES)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (heap_we),
      .wr_addr (heap_wr_addr),
      .wr_data (wr_data),
      .rd_en   (look),
      .rd_addr (heap_off[AW-1:0]),
      .rd_data (heap_rd)
   );
endmodule

[design/ftpo_checker.sv]
// Port-level checker of the first-touch page owner tracker, with its bind.
module ftpo_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [ftpo_pkg::STATUS_W-1:0] rsp_status
);
   // reset empties the response register
   a_reset_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // one access at a time: no transfer in the cycle after a transfer
   a_one_at_a_time: assert property (@(posedge clock)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request ready right after a transfer");

   // only defined status codes are returned
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ftpo_pkg::STATUS_LOCAL
                     || rsp_status == ftpo_pkg::STATUS_REMOTE
                     || rsp_status == ftpo_pkg::STATUS_UNTRACKED))
      else $error("undefined status code");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)))
      else $error("stalled response changed");
endmodule

bind first_touch_page_owner ftpo_checker u_ftpo_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_status (rsp_bus.status)
);

[test/first_touch_page_owner_test.sv]
// Self-checking testbench of the first-touch page owner tracker: directed and random accesses.
`timescale 1ns / 1ps

module first_touch_page_owner_test;

   localparam int PAGE_W           = ftpo_pkg::PAGE_W;
   localparam int ID_W             = ftpo_pkg::ID_W;
   localparam int OWNER_W          = ftpo_pkg::OWNER_W;
   localparam int PAGES            = 4096;
   localparam int SLOT_W           = $clog2(PAGES);
   localparam int RESET_CYCLES     = 9;
   localparam int SETTLE_CYCLES    = 8;
   localparam int RANDOM_PER_PHASE = 125;
   localparam int HOLD_OFF_CYCLES  = 300;
   localparam int TIMEOUT_CYCLES   = 200000;

   localparam logic [PAGE_W-1:0] PAGE_MAX = {PAGE_W{1'b1}};
   localparam logic [PAGE_W-1:0] SPLIT_BASE = 52'h1000;
   localparam logic [PAGE_W-1:0] TABLE_LAST = PAGE_W'(PAGES - 1);
   localparam logic [PAGE_W-1:0] TABLE_SIZE = PAGE_W'(PAGES);

   typedef enum logic {
      REGION_HEAP = 1'b0,
      REGION_MMAP = 1'b1
   } region_type;

   typedef struct packed {
      logic [PAGE_W-1:0] page;
      logic [ID_W-1:0]   node;
   } page_access_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ftpo_req_if req_bus ();
   ftpo_rsp_if rsp_bus ();
   ftpo_csr_if csr_bus ();

   first_touch_page_owner #(
      .PAGES(PAGES)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #2 clock = ~clock;

   // Shadow copy of the bounds and of both owner tables
   logic [PAGE_W-1:0]  heap_lo, heap_hi, mmap_lo, mmap_hi;
   logic [OWNER_W-1:0] node_of_page [2][PAGES];

   page_access_type      access_queue[$];
   ftpo_pkg::status_type status_due[$];

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_off_trigger   = 0;
   int hold_off_seen      = 0;
   int hold_off_left      = 0;
   int mismatches         = 0;
   int accesses_sent      = 0;
   int status_tally [3]   = '{0, 0, 0};
   int cycle_count        = 0;
   logic req_accepted     = 1'b0;

   // Expected status of one access; claims the page as a side effect
   function automatic ftpo_pkg::status_type touch_page(logic [PAGE_W-1:0] page,
                                                       logic [ID_W-1:0] node);
      region_type         region;
      logic [PAGE_W-1:0]  offset;
      logic [OWNER_W-1:0] owner;
      if (mmap_lo <= mmap_hi && page >= mmap_lo && page <= mmap_hi) begin
         region = REGION_MMAP;
         offset = page - mmap_lo;
      end else if (heap_lo <= heap_hi && page >= heap_lo && page <= heap_hi) begin
         region = REGION_HEAP;
         offset = page - heap_lo;
      end else
         return ftpo_pkg::STATUS_UNTRACKED;
      // mmap hit beyond its table does not fall through to the heap
      if (offset >= TABLE_SIZE)
         return ftpo_pkg::STATUS_UNTRACKED;
      owner = node_of_page[region][offset[SLOT_W-1:0]];
      if (owner == ftpo_pkg::UNOWNED) begin
         node_of_page[region][offset[SLOT_W-1:0]] = OWNER_W'(node);
         return ftpo_pkg::STATUS_LOCAL;
      end
      return (owner == OWNER_W'(node)) ? ftpo_pkg::STATUS_LOCAL : ftpo_pkg::STATUS_REMOTE;
   endfunction

   // Random access biased toward the configured regions and a few busy nodes
   function automatic page_access_type random_access();
      page_access_type   acc;
      logic [PAGE_W-1:0] base;
      int unsigned       pick;
      base = ($urandom_range(99) < 55) ? mmap_lo : heap_lo;
      pick = $urandom_range(99);
      if (pick < 45)
         acc.page = base + $urandom_range(63);
      else if (pick < 75)
         acc.page = base + $urandom_range(PAGES - 1);
      else if (pick < 90)
         acc.page = base + $urandom_range(PAGES + 300);
      else
         acc.page = PAGE_W'({$urandom(), $urandom()});
      if ($urandom_range(99) < 60)
         acc.node = ID_W'($urandom_range(3));
      else
         acc.node = ID_W'($urandom());
      return acc;
   endfunction

   task automatic report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
   endtask

   task automatic queue_access(logic [PAGE_W-1:0] page, logic [ID_W-1:0] node);
      access_queue.push_back('{page: page, node: node});
   endtask

   // One register write on the CSR channel, mirrored into the shadow bounds
   task automatic write_bound(logic [ftpo_pkg::CSR_IDX_W-1:0] idx,
                              logic [PAGE_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready)
         @(posedge clock);
      case (idx)
         ftpo_pkg::CSR_HEAP_LOW:  heap_lo = value;
         ftpo_pkg::CSR_HEAP_HIGH: heap_hi = value;
         ftpo_pkg::CSR_MMAP_LOW:  mmap_lo = value;
         ftpo_pkg::CSR_MMAP_HIGH: mmap_hi = value;
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic set_bounds(logic [PAGE_W-1:0] h_lo, logic [PAGE_W-1:0] h_hi,
                             logic [PAGE_W-1:0] m_lo, logic [PAGE_W-1:0] m_hi);
      write_bound(ftpo_pkg::CSR_HEAP_LOW, h_lo);
      write_bound(ftpo_pkg::CSR_HEAP_HIGH, h_hi);
      write_bound(ftpo_pkg::CSR_MMAP_LOW, m_lo);
      write_bound(ftpo_pkg::CSR_MMAP_HIGH, m_hi);
   endtask

   // Wait until every queued access went out and every status came back
   task automatic drain();
      while (access_queue.size() != 0 || req_bus.valid || status_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_random_phase(int sender_pct, int receiver_pct, bit hold_off);
      sender_idle_pct    = sender_pct;
      receiver_stall_pct = receiver_pct;
      repeat (RANDOM_PER_PHASE) access_queue.push_back(random_access());
      if (hold_off)
         hold_off_trigger++;
      drain();
   endtask

   // Request driver: a new access goes out once the previous one transferred
   always @(negedge clock) begin
      page_access_type acc;
      if (!reset && (!req_bus.valid || req_accepted)) begin
         if (access_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            acc = access_queue.pop_front();
            req_bus.valid        <= 1'b1;
            req_bus.page_number  <= acc.page;
            req_bus.requester_id <= acc.node;
         end else
            req_bus.valid <= 1'b0;
      end
   end

   // Response ready: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_off_trigger != hold_off_seen) begin
         hold_off_seen <= hold_off_trigger;
         hold_off_left <= HOLD_OFF_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (hold_off_left > 0) begin
         hold_off_left <= hold_off_left - 1;
         rsp_bus.ready <= 1'b0;
      end else
         rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Monitor: check statuses in order, predict each accepted access
   always @(posedge clock) begin
      ftpo_pkg::status_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (status_due.size() == 0)
            report_mismatch($sformatf("status %0d with no access outstanding",
                                      rsp_bus.status));
         else begin
            want = status_due.pop_front();
            if (rsp_bus.status !== want)
               report_mismatch($sformatf("status %0d, expected %0d", rsp_bus.status, want));
            status_tally[want]++;
         end
      end
      if (!reset && req_bus.valid && req_bus.ready) begin
         status_due.push_back(touch_page(req_bus.page_number, req_bus.requester_id));
         accesses_sent++;
      end
      req_accepted <= !reset && req_bus.valid && req_bus.ready;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= TIMEOUT_CYCLES) begin
         $display("timeout after %0d cycles, %0d statuses outstanding",
                  cycle_count, status_due.size());
         $display("first_touch_page_owner verification failed");
         $finish;
      end
   end

   initial begin
      req_bus.valid        = 1'b0;
      req_bus.page_number  = '0;
      req_bus.requester_id = '0;
      rsp_bus.ready        = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = ftpo_pkg::CSR_HEAP_LOW;
      csr_bus.data         = '0;
      heap_lo = PAGE_MAX;
      heap_hi = '0;
      mmap_lo = PAGE_MAX;
      mmap_hi = '0;
      foreach (node_of_page[r, i])
         node_of_page[r][i] = ftpo_pkg::UNOWNED;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty regions after reset: nothing is tracked
      queue_access('0, '0);
      queue_access(PAGE_MAX, 7'h7F);
      drain();

      // Overlapping regions, heap wider than mmap, both longer than a table
      set_bounds(SPLIT_BASE, SPLIT_BASE + 9000, SPLIT_BASE + 2000, SPLIT_BASE + 6500);
      queue_access(SPLIT_BASE + 2000, 7'd5);   // claim, mmap wins the overlap
      queue_access(SPLIT_BASE + 2000, 7'd5);   // same owner again
      queue_access(SPLIT_BASE + 2000, 7'd6);   // other node
      queue_access(SPLIT_BASE + 6095, 7'h7F);  // last mmap table slot
      queue_access(SPLIT_BASE + 6096, 7'd1);   // past the mmap table, heap not tried
      queue_access(SPLIT_BASE + 6500, 7'd1);   // mmap high bound
      queue_access(SPLIT_BASE + 1000, 7'd2);   // heap only
      queue_access(SPLIT_BASE + 1000, 7'd3);
      queue_access(SPLIT_BASE, 7'd0);          // heap low bound
      queue_access(SPLIT_BASE + 4095, 7'd0);   // heap slot hidden by mmap
      queue_access(SPLIT_BASE + 7000, 7'd0);   // heap past its table
      queue_access(SPLIT_BASE + 9001, 7'd0);   // above both regions
      queue_access(SPLIT_BASE - 1, 7'd0);      // below both regions
      drain();

      // Extreme bounds; old owners stay where they were
      set_bounds('0, TABLE_LAST, PAGE_MAX - TABLE_LAST, PAGE_MAX);
      queue_access('0, 7'h7F);
      queue_access(PAGE_MAX, 7'd0);
      queue_access(PAGE_MAX - TABLE_LAST, 7'h55);
      queue_access(TABLE_LAST, 7'h2A);
      queue_access(TABLE_SIZE, 7'h7F);
      queue_access(PAGE_MAX - TABLE_SIZE, 7'h7F);
      drain();

      // Random phases, each under its own layout and idle pattern
      set_bounds(SPLIT_BASE, SPLIT_BASE + 9000, SPLIT_BASE + 2000, SPLIT_BASE + 6500);
      run_random_phase(0, 0, 1'b1);
      set_bounds(PAGE_MAX, PAGE_MAX, '0, PAGE_MAX);
      run_random_phase(83, 0, 1'b0);
      set_bounds(52'h1234_5678_9AB, 52'h1234_5678_9AB + 6000, 52'd500, 52'd100);
      run_random_phase(0, 83, 1'b0);
      set_bounds('0, TABLE_LAST, PAGE_MAX - TABLE_LAST, PAGE_MAX);
      run_random_phase(24, 24, 1'b0);

      if (status_due.size() != 0)
         report_mismatch($sformatf("%0d statuses never arrived", status_due.size()));
      $display("checked %0d accesses over 5 region layouts: %0d local, %0d remote, %0d untracked",
               accesses_sent, status_tally[ftpo_pkg::STATUS_LOCAL],
               status_tally[ftpo_pkg::STATUS_REMOTE],
               status_tally[ftpo_pkg::STATUS_UNTRACKED]);
      $display("traffic: free flow, sparse sender, stalling receiver, mixed, %0d-cycle hold-off",
               HOLD_OFF_CYCLES);
      if (mismatches == 0)
         $display("first_touch_page_owner verification clean");
      else
         $display("first_touch_page_owner verification failed");
      $finish;
   end

endmodule
